[rtl/sce_pkg.sv]
// Shared types and constants for the sigma-clipped standard error block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sce_pkg;

	localparam int unsigned SAMPLES_DEF = 16;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CF_W        = 12;
	localparam int unsigned CF_RESET    = 640;
	localparam int unsigned ROOT_W      = 31;
	localparam int unsigned KEPT_W      = 7;
	localparam int unsigned S1_W        = 38;
	localparam int unsigned SQ_W        = 69;
	localparam int unsigned DV_W        = 76;
	localparam int unsigned DEV_W       = 40;
	localparam int unsigned D2_W        = 78;
	localparam int unsigned CMP_W       = 106;
	localparam int unsigned NUM_W       = 76;
	localparam int unsigned KK_W        = 13;
	localparam int unsigned DEN_W       = 19;
	localparam int unsigned SQR_W       = 84;
	localparam int unsigned DIV_W       = 39;
	localparam int unsigned MA_W        = 80;
	localparam int unsigned MB_W        = 40;
	localparam int unsigned MP_W        = 120;
	localparam int unsigned OUT_W       = 72;

	typedef struct packed {
		logic                     too_few_kept;
		logic [KEPT_W-1:0]        kept_count;
		logic signed [DATA_W-1:0] mean_value;
		logic [ROOT_W-1:0]        std_error;
	} res_t;

endpackage
`default_nettype wire

[rtl/sigma_clipped_standard_error.sv]
// Top level of the sigma-clipped standard error block: ports, clip factor
// register and output register. Depends on sce_pkg and sce_core.
//
// Usage: samples arrive as beats on the s_axis channel, one signed Q16.16
// value per beat. Every SAMPLES beats form one bin; after the last beat of a
// bin one result beat leaves on m_axis carrying the standard error of the
// clipped mean, the unclipped mean, the kept count and the too-few flag.
// Each input beat is accepted, then squared by the shared four-bit-per-cycle
// multiplier before the next beat is taken. After the last beat of a bin the
// result follows the set-up products, the scaling of the mean and the second
// pass over the sample store, then, when at least two samples are kept, the
// final products and the square root search, and last the output register.
// The clip factor must be written through cfg_wr_en and cfg_wr_data only
// between bins; the block itself does not enforce this. Reset clears the
// partial bin, the accumulators and the output valid flag and sets the clip
// factor to 2.5. A result waiting on a stalled receiver sits in the output
// register while the next bin is already being loaded. Input is held off
// while a sample is squared, while a bin's result is computed, and while a
// second result is ready and the first is still not taken.
`default_nettype none
module sigma_clipped_standard_error #(
	parameter int unsigned SAMPLES = sce_pkg::SAMPLES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// sample_value[31:0]
	input  wire logic [sce_pkg::DATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// std_error[30:0], mean_value[62:31], kept_count[69:63], too_few_kept[70]
	output logic [sce_pkg::OUT_W-1:0]         m_axis_tdata,
	input  wire logic                         cfg_wr_en,
	input  wire logic [sce_pkg::CF_W-1:0]     cfg_wr_data
);
	import sce_pkg::*;

	logic [CF_W-1:0] clip_factor_q;
	logic            res_valid;
	logic            res_ready;
	res_t            res;
	logic            out_valid_q;
	res_t            out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_factor_q <= CF_W'(CF_RESET);
		end else if (cfg_wr_en) begin
			clip_factor_q <= cfg_wr_data;
		end
	end

	sce_core #(
		.SAMPLES (SAMPLES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     ($signed(s_axis_tdata)),
		.clip_factor (clip_factor_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule
`default_nettype wire

[rtl/sce_mul.sv]
// Shared serial multiplier, four bits of the second operand per cycle.
// Depends on sce_pkg for the operand and product widths.
`default_nettype none
module sce_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [sce_pkg::MA_W-1:0] a,
	input  wire logic [sce_pkg::MB_W-1:0] b,
	output logic                          done,
	output logic [sce_pkg::MP_W-1:0]      product
);
	import sce_pkg::*;

	logic [MP_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [MP_W-1:0] acc_q;
	logic            run_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && b_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= MP_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q && b_q != '0) begin
			acc_q <= acc_q + a_q * MP_W'(b_q[3:0]);
			a_q   <= a_q << 4;
			b_q   <= b_q >> 4;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

[rtl/sce_core.sv]
// Sample store, accumulators and the sequencer that drives the shared multiplier,
// the mean scaling and the square root search. Depends on sce_pkg and sce_mul.
`default_nettype none
module sce_core #(
	parameter int unsigned SAMPLES = sce_pkg::SAMPLES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [sce_pkg::DATA_W-1:0] in_data,
	input  wire logic [sce_pkg::CF_W-1:0]   clip_factor,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output sce_pkg::res_t                   res
);
	import sce_pkg::*;

	localparam int unsigned CW    = $clog2(SAMPLES);
	localparam int unsigned BI_W  = $clog2(ROOT_W);
	localparam int unsigned DSH   = DIV_W + CW;
	localparam longint unsigned RECIP =
		((64'd1 << DSH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

	typedef enum logic [4:0] {
		S_IDLE, S_LSQ, S_NSXX, S_S1SQ, S_CFSQ, S_CFN, S_RHS, S_DIV, S_RD, S_NV,
		S_DSQ, S_LHS, S_VSQ, S_KT2, S_T1SQ, S_KK, S_DEN, S_SQA, S_SQB, S_RES
	} state_t;

	state_t state_q;

	logic signed [DATA_W-1:0] mem [SAMPLES];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] x_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            idx_q;
	logic signed [S1_W-1:0]   s1_q;
	logic [SQ_W-1:0]          sxx_q;
	logic [DV_W-1:0]          nsxx_q;
	logic [DV_W-1:0]          dvar_q;
	logic [2*CF_W-1:0]        cfsq_q;
	logic [MB_W-1:0]          cfsqn_q;
	logic [CMP_W-1:0]         rhs_q;
	logic signed [DEV_W-1:0]  dev_q;
	logic [D2_W-1:0]          d2_q;
	logic signed [S1_W-1:0]   t1_q;
	logic [SQ_W-1:0]          t2_q;
	logic [KEPT_W-1:0]        k_q;
	logic [NUM_W-1:0]         kt2_q;
	logic [NUM_W-1:0]         num_q;
	logic [KK_W-1:0]          kk_q;
	logic [DIV_W-1:0]         div_m_q;
	logic [SQR_W-1:0]         p_q;
	logic [SQR_W-1:0]         rs_q;
	logic [SQR_W-1:0]         q4_q;
	logic [SQR_W-1:0]         cand_q;
	logic [ROOT_W-1:0]        root_q;
	logic [BI_W-1:0]          bit_q;
	logic                     mul_busy_q;

	logic                     is_mul;
	logic                     mul_start;
	logic                     mul_done;
	logic [MA_W-1:0]          mul_a;
	logic [MB_W-1:0]          mul_b;
	logic [MP_W-1:0]          prod;
	logic [DATA_W-1:0]        xmag;
	logic [DATA_W-1:0]        vmag;
	logic [S1_W-1:0]          s1mag;
	logic [S1_W-1:0]          t1mag;
	logic [DEV_W-1:0]         devmag;
	logic signed [DEV_W-1:0]  nv_sgn;
	logic signed [DEV_W-1:0]  dev_next;
	logic [CMP_W-1:0]         lhs;
	logic                     drop;
	logic                     last;
	logic                     sq_acc;
	logic [SQR_W-1:0]         rs_sum;
	logic [DIV_W-1:0]         mean_wide;

	assign xmag   = x_q[DATA_W-1] ? DATA_W'(-x_q) : DATA_W'(x_q);
	assign vmag   = rd_q[DATA_W-1] ? DATA_W'(-rd_q) : DATA_W'(rd_q);
	assign s1mag  = s1_q[S1_W-1] ? S1_W'(-s1_q) : S1_W'(s1_q);
	assign t1mag  = t1_q[S1_W-1] ? S1_W'(-t1_q) : S1_W'(t1_q);
	assign devmag = dev_q[DEV_W-1] ? DEV_W'(-dev_q) : DEV_W'(dev_q);
	assign nv_sgn = rd_q[DATA_W-1] ? -$signed(DEV_W'(prod)) : $signed(DEV_W'(prod));
	assign dev_next = nv_sgn - DEV_W'(s1_q);
	assign lhs    = {prod[CMP_W-17:0], 16'h0000};
	assign drop   = (s1_q != '0) && (lhs > rhs_q);
	assign last   = idx_q == CW'(SAMPLES - 1);
	assign sq_acc = cand_q <= SQR_W'(num_q);
	assign rs_sum = rs_q + (sq_acc ? (q4_q << 1) : '0);
	assign mean_wide = s1_q[S1_W-1] ? DIV_W'(-div_m_q) : div_m_q;

	always_comb begin
		is_mul = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_LSQ: begin
				mul_a = MA_W'(xmag);
				mul_b = MB_W'(xmag);
			end
			S_NSXX: begin
				mul_a = MA_W'(sxx_q);
				mul_b = MB_W'(SAMPLES);
			end
			S_S1SQ: begin
				mul_a = MA_W'(s1mag);
				mul_b = MB_W'(s1mag);
			end
			S_CFSQ: begin
				mul_a = MA_W'(clip_factor);
				mul_b = MB_W'(clip_factor);
			end
			S_CFN: begin
				mul_a = MA_W'(cfsq_q);
				mul_b = MB_W'(SAMPLES);
			end
			S_RHS: begin
				mul_a = MA_W'(dvar_q);
				mul_b = cfsqn_q;
			end
			S_DIV: begin
				mul_a = MA_W'(div_m_q);
				mul_b = MB_W'(RECIP);
			end
			S_NV: begin
				mul_a = MA_W'(vmag);
				mul_b = MB_W'(SAMPLES);
			end
			S_DSQ: begin
				mul_a = MA_W'(devmag);
				mul_b = devmag;
			end
			S_LHS: begin
				mul_a = MA_W'(d2_q);
				mul_b = MB_W'(SAMPLES - 1);
			end
			S_VSQ: begin
				mul_a = MA_W'(vmag);
				mul_b = MB_W'(vmag);
			end
			S_KT2: begin
				mul_a = MA_W'(t2_q);
				mul_b = MB_W'(k_q);
			end
			S_T1SQ: begin
				mul_a = MA_W'(t1mag);
				mul_b = MB_W'(t1mag);
			end
			S_KK: begin
				mul_a = MA_W'(k_q);
				mul_b = MB_W'(k_q);
			end
			S_DEN: begin
				mul_a = MA_W'(kk_q);
				mul_b = MB_W'(k_q - KEPT_W'(1));
			end
			default: begin
				is_mul = 1'b0;
			end
		endcase
	end

	assign mul_start = is_mul && !mul_busy_q;

	sce_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mem[cnt_q] <= in_data;
		end
		if (state_q == S_RD) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mul_busy_q <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			s1_q       <= '0;
			sxx_q      <= '0;
			x_q        <= '0;
			nsxx_q     <= '0;
			dvar_q     <= '0;
			cfsq_q     <= '0;
			cfsqn_q    <= '0;
			rhs_q      <= '0;
			dev_q      <= '0;
			d2_q       <= '0;
			t1_q       <= '0;
			t2_q       <= '0;
			k_q        <= '0;
			kt2_q      <= '0;
			num_q      <= '0;
			kk_q       <= '0;
			div_m_q    <= '0;
			p_q        <= '0;
			rs_q       <= '0;
			q4_q       <= '0;
			cand_q     <= '0;
			root_q     <= '0;
			bit_q      <= '0;
		end else begin
			if (is_mul) begin
				if (!mul_busy_q) begin
					mul_busy_q <= 1'b1;
				end else if (mul_done) begin
					mul_busy_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q     <= in_data;
						s1_q    <= s1_q + S1_W'(in_data);
						state_q <= S_LSQ;
					end
				end
				S_LSQ: begin
					if (mul_busy_q && mul_done) begin
						sxx_q <= sxx_q + SQ_W'(prod);
						if (cnt_q == CW'(SAMPLES - 1)) begin
							cnt_q   <= '0;
							state_q <= S_NSXX;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= S_IDLE;
						end
					end
				end
				S_NSXX: begin
					if (mul_busy_q && mul_done) begin
						nsxx_q  <= DV_W'(prod);
						state_q <= S_S1SQ;
					end
				end
				S_S1SQ: begin
					if (mul_busy_q && mul_done) begin
						dvar_q  <= nsxx_q - DV_W'(prod);
						state_q <= S_CFSQ;
					end
				end
				S_CFSQ: begin
					if (mul_busy_q && mul_done) begin
						cfsq_q  <= (2*CF_W)'(prod);
						state_q <= S_CFN;
					end
				end
				S_CFN: begin
					if (mul_busy_q && mul_done) begin
						cfsqn_q <= MB_W'(prod);
						state_q <= S_RHS;
					end
				end
				S_RHS: begin
					if (mul_busy_q && mul_done) begin
						rhs_q   <= CMP_W'(prod);
						div_m_q <= DIV_W'(s1mag)
							+ (s1_q[S1_W-1] ? DIV_W'(SAMPLES - 1) : '0);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (mul_busy_q && mul_done) begin
						div_m_q <= DIV_W'(prod >> DSH);
						idx_q   <= '0;
						t1_q    <= '0;
						t2_q    <= '0;
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_NV;
				end
				S_NV: begin
					if (mul_busy_q && mul_done) begin
						dev_q   <= dev_next;
						state_q <= S_DSQ;
					end
				end
				S_DSQ: begin
					if (mul_busy_q && mul_done) begin
						d2_q    <= D2_W'(prod);
						state_q <= S_LHS;
					end
				end
				S_LHS: begin
					if (mul_busy_q && mul_done) begin
						if (drop) begin
							idx_q <= idx_q + CW'(1);
							if (last) begin
								state_q <= (k_q < KEPT_W'(2)) ? S_RES : S_KT2;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							t1_q    <= t1_q + S1_W'(rd_q);
							k_q     <= k_q + KEPT_W'(1);
							state_q <= S_VSQ;
						end
					end
				end
				S_VSQ: begin
					if (mul_busy_q && mul_done) begin
						t2_q  <= t2_q + SQ_W'(prod);
						idx_q <= idx_q + CW'(1);
						if (last) begin
							state_q <= (k_q < KEPT_W'(2)) ? S_RES : S_KT2;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_KT2: begin
					if (mul_busy_q && mul_done) begin
						kt2_q   <= NUM_W'(prod);
						state_q <= S_T1SQ;
					end
				end
				S_T1SQ: begin
					if (mul_busy_q && mul_done) begin
						num_q   <= kt2_q - NUM_W'(prod);
						state_q <= S_KK;
					end
				end
				S_KK: begin
					if (mul_busy_q && mul_done) begin
						kk_q    <= KK_W'(prod);
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					if (mul_busy_q && mul_done) begin
						p_q     <= '0;
						rs_q    <= '0;
						q4_q    <= SQR_W'(prod[DEN_W-1:0]) << (2*(ROOT_W-1));
						root_q  <= '0;
						bit_q   <= BI_W'(ROOT_W - 1);
						state_q <= S_SQA;
					end
				end
				S_SQA: begin
					cand_q  <= p_q + rs_q + q4_q;
					state_q <= S_SQB;
				end
				S_SQB: begin
					if (sq_acc) begin
						p_q           <= cand_q;
						root_q[bit_q] <= 1'b1;
					end
					rs_q <= rs_sum >> 1;
					q4_q <= q4_q >> 2;
					if (bit_q == '0) begin
						state_q <= S_RES;
					end else begin
						bit_q   <= bit_q - BI_W'(1);
						state_q <= S_SQA;
					end
				end
				S_RES: begin
					if (res_ready) begin
						s1_q    <= '0;
						sxx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_RES;

	always_comb begin
		res.too_few_kept = k_q < KEPT_W'(2);
		res.kept_count   = k_q;
		res.mean_value   = DATA_W'(mean_wide);
		res.std_error    = (k_q < KEPT_W'(2)) ? '0 : root_q;
	end

endmodule
`default_nettype wire

[rtl/sce_checker.sv]
// Port-level checks for the sigma-clipped standard error block, bound to the
// top level. Depends on sce_pkg and sigma_clipped_standard_error.
`default_nettype none
module sce_checker #(
	parameter int unsigned SAMPLES = sce_pkg::SAMPLES_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [sce_pkg::OUT_W-1:0]  m_axis_tdata
);
	import sce_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result beat changed while stalled.");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input accepted while the previous sample was being squared.");

	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[70] == (m_axis_tdata[69:64] == 6'd0))
		else $error("Too-few flag disagrees with the kept count.");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[70] |-> m_axis_tdata[30:0] == 31'd0)
		else $error("Standard error not zero with too few samples kept.");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[69:63] <= 7'(SAMPLES))
		else $error("Kept count exceeds the bin size.");

endmodule

bind sigma_clipped_standard_error sce_checker #(
	.SAMPLES (SAMPLES)
) u_sce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
